// File: src/cle_pkg.sv
package cle_pkg;

  // default depth of the line store
  localparam int unsigned MAX_LINE_DEF = 32;

  // configuration register
  localparam int unsigned CAP_W = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // special bytes
  localparam logic [7:0] KEY_BACKSPACE = 8'd127;
  localparam logic [7:0] KEY_ENTER     = 8'd13;

  // keyword table, first character at element 0
  localparam int unsigned KW_MAX_LEN = 7;
  localparam int unsigned KW_COUNT   = 4;
  localparam int unsigned KW_LEN_W   = 3;

  typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;

  localparam kw_text_t KW_IP      = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "p", "i"};
  localparam kw_text_t KW_INFO    = {8'h00, 8'h00, 8'h00, "o", "f", "n", "i"};
  localparam kw_text_t KW_HELP    = {8'h00, 8'h00, 8'h00, "p", "l", "e", "h"};
  localparam kw_text_t KW_MONITOR = {"r", "o", "t", "i", "n", "o", "m"};

  // command codes
  typedef enum logic [2:0] {
    CMD_IP           = 3'd0,
    CMD_INFO         = 3'd1,
    CMD_HELP         = 3'd2,
    CMD_MONITOR      = 3'd3,
    CMD_UNRECOGNIZED = 3'd4
  } cmd_code_e;

  // keyword text by table position
  function automatic kw_text_t kw_text(input logic [1:0] k);
    kw_text_t t;
    case (k)
      2'd0:    t = KW_IP;
      2'd1:    t = KW_INFO;
      2'd2:    t = KW_HELP;
      default: t = KW_MONITOR;
    endcase
    return t;
  endfunction

  // keyword length by table position
  function automatic logic [KW_LEN_W-1:0] kw_len(input logic [1:0] k);
    logic [KW_LEN_W-1:0] l;
    case (k)
      2'd0:    l = 3'd2;
      2'd1:    l = 3'd4;
      2'd2:    l = 3'd4;
      default: l = 3'd7;
    endcase
    return l;
  endfunction

  // keyword code by table position
  function automatic cmd_code_e kw_code(input logic [1:0] k);
    cmd_code_e c;
    case (k)
      2'd0:    c = CMD_IP;
      2'd1:    c = CMD_INFO;
      2'd2:    c = CMD_HELP;
      default: c = CMD_MONITOR;
    endcase
    return c;
  endfunction

  // one result transaction
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       command_valid;
    cmd_code_e  command_code;
  } cle_result_t;

endpackage

// File: src/cle_match.sv
module cle_match #(
  parameter int unsigned CNT_W = 6
) (
  input  logic [cle_pkg::KW_MAX_LEN-1:0][7:0] head_i,
  input  logic [CNT_W-1:0]                    count_i,
  output cle_pkg::cmd_code_e                  code_o
);

  logic [cle_pkg::KW_COUNT-1:0] hit;

  // per keyword: length equal and every used character equal
  always_comb begin
    cle_pkg::kw_text_t txt;
    logic [cle_pkg::KW_LEN_W-1:0] len;
    for (int k = 0; k < cle_pkg::KW_COUNT; k++) begin
      txt = cle_pkg::kw_text(2'(k));
      len = cle_pkg::kw_len(2'(k));
      hit[k] = (count_i == CNT_W'(len));
      for (int i = 0; i < cle_pkg::KW_MAX_LEN; i++) begin
        if ((i < int'(len)) && (head_i[i] != txt[i])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // first hit wins
  always_comb begin
    code_o = cle_pkg::CMD_UNRECOGNIZED;
    for (int k = cle_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        code_o = cle_pkg::kw_code(2'(k));
      end
    end
  end

endmodule

// File: src/cle_line.sv
module cle_line #(
  parameter int unsigned MAX_LINE = cle_pkg::MAX_LINE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cle_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                     step_i,
  input  logic [7:0]               byte_i,
  output cle_pkg::cle_result_t     result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);
  localparam int unsigned CMP_W = (CNT_W > cle_pkg::CAP_W) ? CNT_W : cle_pkg::CAP_W;

  logic [cle_pkg::CAP_W-1:0] cap_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      full_q, full_d;
  logic [cle_pkg::KW_MAX_LEN-1:0][7:0] head_q;

  logic [CMP_W-1:0] cap_ext, cap_eff, cnt_ext, cnt_dec, cnt_inc;
  logic             is_bs, is_enter, do_bs, do_append, head_we;
  cle_pkg::cmd_code_e code;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cle_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // effective capacity clamped to 1..MAX_LINE
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_LINE)) begin
      cap_eff = CMP_W'(MAX_LINE);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign cnt_ext  = CMP_W'(count_q);
  assign cnt_dec  = cnt_ext - CMP_W'(1);
  assign cnt_inc  = cnt_ext + CMP_W'(1);
  assign is_bs    = (byte_i == cle_pkg::KEY_BACKSPACE);
  assign is_enter = (byte_i == cle_pkg::KEY_ENTER);
  assign do_bs    = is_bs && (count_q != '0);
  assign do_append = !is_bs && !is_enter && !full_q && (cnt_ext < cap_eff);

  // only the leading characters can ever match a keyword
  assign head_we = do_append && (cnt_ext < CMP_W'(cle_pkg::KW_MAX_LEN));

  cle_match #(
    .CNT_W (CNT_W)
  ) u_match (
    .head_i  (head_q),
    .count_i (count_q),
    .code_o  (code)
  );

  // count and full flag update
  always_comb begin
    count_d = count_q;
    full_d  = full_q;
    if (do_bs) begin
      count_d = CNT_W'(cnt_dec);
      if (cnt_dec < cap_eff) begin
        full_d = 1'b0;
      end
    end else if (is_enter) begin
      count_d = '0;
      full_d  = 1'b0;
    end else if (do_append) begin
      count_d = CNT_W'(cnt_inc);
      if (cnt_inc >= cap_eff) begin
        full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      full_q  <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      full_q  <= full_d;
    end
  end

  // leading characters of the line
  always_ff @(posedge clk_i) begin
    if (step_i && head_we) begin
      head_q[count_q[2:0]] <= byte_i;
    end
  end

  // result of this byte
  always_comb begin
    result_o.echo_valid    = do_bs || do_append;
    result_o.echo_byte     = (do_bs || do_append) ? byte_i : 8'd0;
    result_o.command_valid = is_enter;
    result_o.command_code  = is_enter ? code : cle_pkg::CMD_IP;
  end

endmodule

// File: src/cli_line_editor_command_match.sv
// Line editor for a serial console with keyword matching.
// Input channel: one received byte per transaction (in_valid_i / in_stall_o).
// Output channel: exactly one result transaction per input byte
// (out_valid_o / out_stall_i): echo flag and byte, command flag and code.
// Backspace (127) removes the last character and echoes it when the line is
// not empty; enter (13) reports ip, info, help, monitor or unrecognized and
// clears the line; other bytes are appended and echoed until the line is full.
// Configuration: cfg_valid_i / cfg_ready_o writes line_capacity; ready is
// always high, writes are expected only while the block is idle.
// Each byte passes through the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled, with the
// character count updated as each byte steps.
// Reset: empty line, capacity 32, both pipeline registers empty.
// A stall at the output holds the result; the input register still takes one
// more byte, after which in_stall_o follows out_stall_i.
module cli_line_editor_command_match #(
  parameter int unsigned MAX_LINE = cle_pkg::MAX_LINE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cle_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      echo_valid_o,
  output logic [7:0]                echo_byte_o,
  output logic                      command_valid_o,
  output logic [2:0]                command_code_o
);

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic                 adv, in_take;
  cle_pkg::cle_result_t result, result_q;
  logic                 out_valid_q;

  assign cfg_ready_o = 1'b1;

  // pipeline moves when the result register is free or being emptied
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= rx_byte_i;
    end
  end

  cle_line #(
    .MAX_LINE (MAX_LINE)
  ) u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_valid_q && adv),
    .byte_i     (byte_q),
    .result_o   (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign echo_valid_o    = result_q.echo_valid;
  assign echo_byte_o     = result_q.echo_byte;
  assign command_valid_o = result_q.command_valid;
  assign command_code_o  = result_q.command_code;

endmodule

// File: tb/cli_line_editor_command_match_test.sv
`timescale 1ns / 1ps

module cli_line_editor_command_match_test;

  localparam int unsigned ITEM_TARGET = 1830;
  localparam int unsigned QUIET_LIMIT = 5000;

  // tracks the expected line state and the results still owed by the block
  class line_scoreboard;
    logic [7:0]           line_chars [cle_pkg::MAX_LINE_DEF];
    int unsigned          char_cnt;
    bit                   full;
    logic [5:0]           capacity;
    string                words [4];
    cle_pkg::cmd_code_e   codes [4];
    cle_pkg::cle_result_t expected_q [$];
    int unsigned          errors, bytes_seen, echoes, commands, recognized;

    function new();
      foreach (line_chars[i]) line_chars[i] = '0;
      char_cnt = 0;
      full = 1'b0;
      capacity = cle_pkg::CAP_RESET;
      words = '{"ip", "info", "help", "monitor"};
      codes = '{cle_pkg::CMD_IP, cle_pkg::CMD_INFO, cle_pkg::CMD_HELP,
                cle_pkg::CMD_MONITOR};
      errors = 0;
      bytes_seen = 0;
      echoes = 0;
      commands = 0;
      recognized = 0;
    endfunction

    function void set_capacity(logic [5:0] v);
      capacity = v;
    endfunction

    // capacity clamped to 1 .. line depth
    function int unsigned limit();
      if (capacity == 0) return 1;
      if (capacity > cle_pkg::MAX_LINE_DEF) return cle_pkg::MAX_LINE_DEF;
      return capacity;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // whole-line compare, length first
    function cle_pkg::cmd_code_e match_keyword();
      bit same;
      for (int k = 0; k < 4; k++) begin
        if (words[k].len() != char_cnt) continue;
        same = 1'b1;
        for (int i = 0; i < char_cnt; i++)
          if (line_chars[i] != words[k][i]) same = 1'b0;
        if (same) return codes[k];
      end
      return cle_pkg::CMD_UNRECOGNIZED;
    endfunction

    // accepted input transaction: update the line and queue its result
    function void note_byte(logic [7:0] b);
      cle_pkg::cle_result_t r;
      int unsigned lim;
      r = '0;
      lim = limit();
      bytes_seen++;
      if (b == cle_pkg::KEY_BACKSPACE) begin
        if (char_cnt > 0) begin
          char_cnt--;
          line_chars[char_cnt] = '0;
          if (char_cnt < lim) full = 1'b0;
          r.echo_valid = 1'b1;
          r.echo_byte = b;
        end
      end else if (b == cle_pkg::KEY_ENTER) begin
        r.command_valid = 1'b1;
        r.command_code = match_keyword();
        foreach (line_chars[i]) line_chars[i] = '0;
        char_cnt = 0;
        full = 1'b0;
        commands++;
        if (r.command_code != cle_pkg::CMD_UNRECOGNIZED) recognized++;
      end else if (!full && char_cnt < lim) begin
        line_chars[char_cnt] = b;
        char_cnt++;
        if (char_cnt >= lim) full = 1'b1;
        r.echo_valid = 1'b1;
        r.echo_byte = b;
      end
      if (r.echo_valid) echoes++;
      expected_q.push_back(r);
    endfunction

    function void report(string field, int unsigned want_v, int unsigned got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(logic ev, logic [7:0] eb, logic cv, logic [2:0] cc);
      cle_pkg::cle_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %0b %0d %0b %0d",
                 $time, ev, eb, cv, cc);
        return;
      end
      want = expected_q.pop_front();
      if (ev !== want.echo_valid) report("echo_valid", want.echo_valid, ev);
      if (eb !== want.echo_byte) report("echo_byte", want.echo_byte, eb);
      if (cv !== want.command_valid) report("command_valid", want.command_valid, cv);
      if (cc !== want.command_code) report("command_code", want.command_code, cc);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [cle_pkg::CAP_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                rx_byte = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      echo_valid;
  logic [7:0]                echo_byte;
  logic                      command_valid;
  logic [2:0]                command_code;

  bit             idle_en = 1'b1;
  int unsigned    items_sent = 0;
  int unsigned    caps_written = 0;
  int unsigned    quiet_cycles = 0;
  line_scoreboard sb;

  cli_line_editor_command_match u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .echo_valid_o   (echo_valid),
    .echo_byte_o    (echo_byte),
    .command_valid_o(command_valid),
    .command_code_o (command_code)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // random backpressure on the result channel
  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(0, 99) < 20);
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall)
        sb.check_result(echo_valid, echo_byte, command_valid, command_code);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", QUIET_LIMIT);
      $display("cli_line_editor_command_match_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_char();
    return 8'($urandom_range(32, 126));
  endfunction

  // one input transaction, with an optional random gap in front
  task automatic send_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the sender until every result is back, then cover the pipeline
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [5:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(v);
    caps_written++;
  endtask

  initial begin
    logic [5:0]  cap_plan [9];
    string       w;
    int unsigned n, pos, phase, phase_end;

    cap_plan = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd7, 6'd2, 6'd4, 6'd33, 6'd5};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keywords, edited keyword, empty line, empty backspace, byte extremes
    send_text("ip");
    send_byte(cle_pkg::KEY_ENTER);
    send_text("monitor");
    send_byte(cle_pkg::KEY_ENTER);
    send_text("infx");
    send_byte(cle_pkg::KEY_BACKSPACE);
    send_byte("o");
    send_byte(cle_pkg::KEY_ENTER);
    send_byte(cle_pkg::KEY_ENTER);
    send_byte(cle_pkg::KEY_BACKSPACE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cle_pkg::KEY_ENTER);

    // capacity lowered under a partial line
    send_text("abc");
    write_capacity(6'd2);
    send_byte("x");
    send_byte(cle_pkg::KEY_BACKSPACE);
    send_byte("z");
    send_byte(cle_pkg::KEY_ENTER);

    // random phases, each with its own capacity
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      write_capacity(phase < 9 ? cap_plan[phase] : 6'($urandom_range(0, 63)));
      idle_en = (phase != 4);
      phase_end = items_sent + (phase == 4 ? 250 : $urandom_range(80, 200));
      while (items_sent < phase_end) begin
        w = sb.words[$urandom_range(0, 3)];
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // keyword, sometimes with a corrected typo
            pos = $urandom_range(0, w.len() + 2);
            for (int i = 0; i < w.len(); i++) begin
              send_byte(w[i]);
              if (i == pos) begin
                send_byte(rand_char());
                send_byte(cle_pkg::KEY_BACKSPACE);
              end
            end
          end
          4: begin
            // one character off
            w[$urandom_range(0, w.len() - 1)] = rand_char();
            send_text(w);
          end
          5: begin
            // truncated or extended keyword
            n = $urandom_range(0, w.len() + 2);
            for (int i = 0; i < n; i++) send_byte(i < w.len() ? w[i] : rand_char());
          end
          6: begin
            // raw noise over the whole byte range
            repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
          end
          7: begin
            // overfill, then a few deletes
            repeat (sb.limit() + $urandom_range(1, 4)) send_byte(rand_char());
            repeat ($urandom_range(0, 3)) send_byte(cle_pkg::KEY_BACKSPACE);
          end
          8: begin
            // more deletes than characters, then a keyword
            n = $urandom_range(0, 3);
            repeat (n) send_byte(rand_char());
            repeat (n + $urandom_range(1, 3)) send_byte(cle_pkg::KEY_BACKSPACE);
            send_text(w);
          end
          default: begin
            // zero byte behind a keyword, sometimes removed again
            send_text(w);
            send_byte(8'h00);
            if ($urandom_range(0, 1)) send_byte(cle_pkg::KEY_BACKSPACE);
          end
        endcase
        send_byte(cle_pkg::KEY_ENTER);
      end
      // leave a partial line for the next capacity
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) send_byte(rand_char());
      phase++;
    end

    idle_en = 1'b1;
    wait_drained();
    $display("run covered %0d bytes under %0d capacity writes: %0d echoes, %0d lines",
             sb.bytes_seen, caps_written, sb.echoes, sb.commands);
    $display("%0d lines matched a keyword, %0d errors", sb.recognized, sb.errors);
    if (sb.errors == 0) begin
      $display("cli_line_editor_command_match_test: PASS");
    end else begin
      $display("cli_line_editor_command_match_test: FAIL");
    end
    $finish;
  end

endmodule
